/* rtl/pps_pkg.sv */
// Package for the particle pair selector: widths, register indexes and the
// structs passed between the input stage, the evaluation logic and the state stage.
// No dependencies.
package pps_pkg;

	localparam int VAL_W     = 32;               // Q16.16 lengths and times
	localparam int N_PART    = 256;              // particle slots in the mark table
	localparam int IDX_W     = $clog2(N_PART);   // particle index width
	localparam int CF_W      = 16;               // contact factor, Q4.12
	localparam int CF_FRAC   = 12;               // fraction bits of the contact factor
	localparam int CNT_W     = 8;                // formed pair counter
	localparam int CFG_IDX_W = 3;                // config register index width

	localparam logic [CNT_W-1:0] CNT_MAX        = {CNT_W{1'b1}};
	localparam logic [CF_W-1:0]  CF_RESET       = CF_W'(1 << CF_FRAC);
	localparam logic [VAL_W-1:0] TIME_LIM_RESET = {VAL_W{1'b1}};

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BOUND_RADIUS   = 3'd0,
		CFG_SHELL_MARGIN   = 3'd1,
		CFG_CONTACT_FACTOR = 3'd2,
		CFG_MIN_TIME_STEP  = 3'd3,
		CFG_INIT_TIME_LIM  = 3'd4
	} cfg_reg_t;

	// one request as taken from the input port
	typedef struct packed {
		logic             start_req;
		logic [IDX_W-1:0] first_particle;
		logic [IDX_W-1:0] second_particle;
		logic [VAL_W-1:0] distance;
		logic [VAL_W-1:0] pair_time;
		logic [VAL_W-1:0] first_radius;
		logic [VAL_W-1:0] second_radius;
		logic [VAL_W-1:0] first_center_dist;
		logic [VAL_W-1:0] second_center_dist;
		logic             either_dissociates;
		logic [VAL_W-1:0] first_boundary_time;
		logic [VAL_W-1:0] second_boundary_time;
	} item_t;

	// state-independent results of one request
	typedef struct packed {
		logic             start_req;
		logic             contact;      // distance below the contact limit
		logic             dissociates;
		logic             first_in;     // first shell inside the boundary
		logic             second_in;    // second shell inside the boundary
		logic [IDX_W-1:0] first_idx;
		logic [IDX_W-1:0] second_idx;
		logic [VAL_W-1:0] distance;
		logic [VAL_W-1:0] pair_time;
		logic [VAL_W-1:0] t_unmarked;   // lowering time when both unmarked
		logic [VAL_W-1:0] t_disso;      // lowering time when dissociating
	} eval_t;

endpackage

/* rtl/particle_pair_selector.sv */
// Top level of the particle pair selector: config registers, two-stage pipeline,
// mark table and pass state. Depends on pps_pkg and pps_eval.
//
//   port group   dir   handshake             payload
//   in_*         in    in_valid / in_stall   candidate pair request fields
//   out_*        out   out_valid / out_stall one result per request
//   cfg_*        in    cfg_we                cfg_index, cfg_data (write only)
//
// A request accepted on the input is held in the stage-1 register and its result
// is registered in the stage-2 result and state registers; one request per cycle
// is sustained while out_stall is low. The contact multiply, shell compares and
// the update of marks, minimum, flags and count run combinationally from stage 1
// into the result and state registers (stage 2). Each stage loads when empty or
// when it moves on, so at most two requests are held and in_stall rises only
// while both wait under out_stall. Reset (arst_n) empties both stages, restores
// the config registers and loads the pass state as if a pass had just begun.
module particle_pair_selector (
	input  logic                              clk,
	input  logic                              arst_n,
	// config write port
	input  logic                              cfg_we,
	input  logic [pps_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pps_pkg::VAL_W-1:0]         cfg_data,
	// request channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              start_req,
	input  logic [pps_pkg::IDX_W-1:0]         first_particle,
	input  logic [pps_pkg::IDX_W-1:0]         second_particle,
	input  logic [pps_pkg::VAL_W-1:0]         distance,
	input  logic [pps_pkg::VAL_W-1:0]         pair_time,
	input  logic [pps_pkg::VAL_W-1:0]         first_radius,
	input  logic [pps_pkg::VAL_W-1:0]         second_radius,
	input  logic [pps_pkg::VAL_W-1:0]         first_center_dist,
	input  logic [pps_pkg::VAL_W-1:0]         second_center_dist,
	input  logic                              either_dissociates,
	input  logic [pps_pkg::VAL_W-1:0]         first_boundary_time,
	input  logic [pps_pkg::VAL_W-1:0]         second_boundary_time,
	// result channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              formed_pair,
	output logic [pps_pkg::IDX_W-1:0]         pair_first,
	output logic [pps_pkg::IDX_W-1:0]         pair_second,
	output logic [pps_pkg::VAL_W-1:0]         pair_distance,
	output logic [pps_pkg::CNT_W-1:0]         pair_count,
	output logic [pps_pkg::VAL_W-1:0]         time_step,
	output logic                              three_body,
	output logic                              pass_active
);
	import pps_pkg::*;

	// config registers
	logic [VAL_W-1:0] bound_radius_q;
	logic [VAL_W-1:0] shell_margin_q;
	logic [CF_W-1:0]  contact_factor_q;
	logic [VAL_W-1:0] min_time_step_q;
	logic [VAL_W-1:0] init_time_lim_q;

	// pipeline
	logic   v_s1, v_s2;
	item_t  item_s1;
	eval_t  ev_comb;
	logic   rdy_s1, rdy_s2;
	logic   adv_s2;

	// pass state
	logic [N_PART-1:0] marks_q;
	logic [VAL_W-1:0]  min_q;
	logic              tb_q;
	logic              act_q;
	logic [CNT_W-1:0]  cnt_q;

	// result registers
	logic              formed_s2;
	logic [IDX_W-1:0]  pfirst_s2;
	logic [IDX_W-1:0]  psecond_s2;
	logic [VAL_W-1:0]  pdist_s2;

	// next-state logic
	logic [N_PART-1:0] marks_d;
	logic [VAL_W-1:0]  min_d;
	logic              tb_d;
	logic              act_d;
	logic [CNT_W-1:0]  cnt_d;
	logic              formed_d;
	logic              unmarked;
	logic [VAL_W-1:0]  t_low;
	logic [VAL_W-1:0]  min_low;

	// ---- config writes; indexes past the list are dropped ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bound_radius_q   <= '0;
			shell_margin_q   <= '0;
			contact_factor_q <= CF_RESET;
			min_time_step_q  <= '0;
			init_time_lim_q  <= TIME_LIM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BOUND_RADIUS:   bound_radius_q   <= cfg_data;
				CFG_SHELL_MARGIN:   shell_margin_q   <= cfg_data;
				CFG_CONTACT_FACTOR: contact_factor_q <= cfg_data[CF_W-1:0];
				CFG_MIN_TIME_STEP:  min_time_step_q  <= cfg_data;
				CFG_INIT_TIME_LIM:  init_time_lim_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---- stage ready chain: a stage loads when empty or when it moves on ----
	assign rdy_s2   = !v_s2 || !out_stall;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_stall = !rdy_s1;
	assign adv_s2   = v_s1 && rdy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
		end
	end

	// stage 1: request register
	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			item_s1.start_req            <= start_req;
			item_s1.first_particle       <= first_particle;
			item_s1.second_particle      <= second_particle;
			item_s1.distance             <= distance;
			item_s1.pair_time            <= pair_time;
			item_s1.first_radius         <= first_radius;
			item_s1.second_radius        <= second_radius;
			item_s1.first_center_dist    <= first_center_dist;
			item_s1.second_center_dist   <= second_center_dist;
			item_s1.either_dissociates   <= either_dissociates;
			item_s1.first_boundary_time  <= first_boundary_time;
			item_s1.second_boundary_time <= second_boundary_time;
		end
	end

	// contact multiply and shell compares, no pass state involved
	pps_eval u_eval (
		.item           (item_s1),
		.bound_radius   (bound_radius_q),
		.shell_margin   (shell_margin_q),
		.contact_factor (contact_factor_q),
		.ev             (ev_comb)
	);

	// ---- stage 2: pass state update ----
	// A start request behaves as if the pass had just been reset, then the
	// request itself is treated against that fresh state.
	always_comb begin
		marks_d  = ev_comb.start_req ? '0 : marks_q;
		min_d    = ev_comb.start_req ? init_time_lim_q : min_q;
		tb_d     = ev_comb.start_req ? 1'b0 : tb_q;
		act_d    = ev_comb.start_req ? 1'b1 : act_q;
		cnt_d    = ev_comb.start_req ? '0 : cnt_q;
		formed_d = 1'b0;

		unmarked = !marks_d[ev_comb.first_idx] && !marks_d[ev_comb.second_idx];
		// lowering time: dissociating, both unmarked, or marked (pair time alone)
		if (ev_comb.dissociates)
			t_low = ev_comb.t_disso;
		else if (unmarked)
			t_low = ev_comb.t_unmarked;
		else
			t_low = ev_comb.pair_time;
		min_low = (t_low < min_d) ? t_low : min_d;

		if (act_d) begin
			if (!ev_comb.contact) begin
				act_d = 1'b0;
			end else if (ev_comb.dissociates) begin
				min_d = min_low;
			end else if (unmarked && ev_comb.first_in && ev_comb.second_in) begin
				formed_d                    = 1'b1;
				marks_d[ev_comb.first_idx]  = 1'b1;
				marks_d[ev_comb.second_idx] = 1'b1;
				if (cnt_d != CNT_MAX)
					cnt_d = cnt_d + 1'b1;
			end else begin
				min_d = min_low;
				if (min_low < min_time_step_q) begin
					tb_d  = 1'b1;
					act_d = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marks_q <= '0;
			min_q   <= TIME_LIM_RESET;
			tb_q    <= 1'b0;
			act_q   <= 1'b1;
			cnt_q   <= '0;
		end else if (adv_s2) begin
			marks_q <= marks_d;
			min_q   <= min_d;
			tb_q    <= tb_d;
			act_q   <= act_d;
			cnt_q   <= cnt_d;
		end
	end

	// pair fields read as zero unless a pair was formed
	always_ff @(posedge clk) begin
		if (adv_s2) begin
			formed_s2  <= formed_d;
			pfirst_s2  <= formed_d ? ev_comb.first_idx : '0;
			psecond_s2 <= formed_d ? ev_comb.second_idx : '0;
			pdist_s2   <= formed_d ? ev_comb.distance : '0;
		end
	end

	// running state registers hold the values after the request in stage 2
	assign out_valid     = v_s2;
	assign formed_pair   = formed_s2;
	assign pair_first    = pfirst_s2;
	assign pair_second   = psecond_s2;
	assign pair_distance = pdist_s2;
	assign pair_count    = cnt_q;
	assign time_step     = min_q;
	assign three_body    = tb_q;
	assign pass_active   = act_q;

endmodule

/* rtl/pps_eval.sv */
// Evaluation logic of the particle pair selector: contact test, shell tests and
// candidate lowering times for one request. Depends on pps_pkg.
module pps_eval (
	input  pps_pkg::item_t                  item,
	input  logic [pps_pkg::VAL_W-1:0]       bound_radius,
	input  logic [pps_pkg::VAL_W-1:0]       shell_margin,
	input  logic [pps_pkg::CF_W-1:0]        contact_factor,
	output pps_pkg::eval_t                  ev
);
	import pps_pkg::*;

	localparam int PROD_W = VAL_W + CF_W + 1;

	logic [VAL_W:0]         rsum;
	logic [PROD_W-1:0]      prod;
	logic [PROD_W-1:0]      dscaled;
	logic [VAL_W:0]         shell1;
	logic [VAL_W:0]         shell2;
	logic                   limit_ok;
	logic [VAL_W-1:0]       limit;
	logic [VAL_W-1:0]       max1;
	logic [VAL_W-1:0]       max2;

	// distance * 2^12 < factor * (r1 + r2), exact
	assign rsum    = {1'b0, item.first_radius} + {1'b0, item.second_radius};
	assign prod    = PROD_W'(rsum) * PROD_W'(contact_factor);
	assign dscaled = PROD_W'({item.distance, {CF_FRAC{1'b0}}});

	// shell = center distance + radius, kept at full width so a carry reads as outside
	assign shell1   = {1'b0, item.first_center_dist} + {1'b0, item.first_radius};
	assign shell2   = {1'b0, item.second_center_dist} + {1'b0, item.second_radius};
	assign limit_ok = shell_margin <= bound_radius;
	assign limit    = bound_radius - shell_margin;

	assign max1 = (item.pair_time > item.first_boundary_time) ?
		item.pair_time : item.first_boundary_time;
	assign max2 = (item.pair_time > item.second_boundary_time) ?
		item.pair_time : item.second_boundary_time;

	always_comb begin
		ev.start_req   = item.start_req;
		ev.contact     = dscaled < prod;
		ev.dissociates = item.either_dissociates;
		ev.first_in    = limit_ok && (shell1 < {1'b0, limit});
		ev.second_in   = limit_ok && (shell2 < {1'b0, limit});
		ev.first_idx   = item.first_particle;
		ev.second_idx  = item.second_particle;
		ev.distance    = item.distance;
		ev.pair_time   = item.pair_time;
		// first inside, second outside takes the second boundary time
		ev.t_unmarked  = ev.first_in ? max2 : max1;
		ev.t_disso     = max2;
	end

endmodule

/* verif/tb.sv */
// Self-checking bench for particle_pair_selector: random and directed requests,
// a scoreboard that predicts each result, and random stalls on both channels.
// Depends on rtl/pps_pkg.sv, rtl/particle_pair_selector.sv and rtl/pps_eval.sv.
`timescale 1ns / 1ps

module tb;
	import pps_pkg::*;

	localparam int SETTLE      = 6;     // pipeline is two deep
	localparam int LONG_HOLD   = 100;   // receiver hold-off for the fill test
	localparam int IDLE_LIMIT  = 2000;  // cycles without any transfer
	localparam int NUM_PHASES  = 8;
	localparam int PHASE_CAP   = 400;   // raw requests per phase
	localparam int PRINT_LIMIT = 40;

	// one result as seen on the output port
	typedef struct packed {
		logic             formed;
		logic [IDX_W-1:0] first;
		logic [IDX_W-1:0] second;
		logic [VAL_W-1:0] pdist;
		logic [CNT_W-1:0] count;
		logic [VAL_W-1:0] tstep;
		logic             three;
		logic             active;
	} result_t;

	// Tracks the selector's pass state and config, and holds the results
	// still owed by the block in request order.
	class pair_ledger;
		logic [VAL_W-1:0]  bound_radius;
		logic [VAL_W-1:0]  shell_margin;
		logic [CF_W-1:0]   contact_factor;
		logic [VAL_W-1:0]  min_time_step;
		logic [VAL_W-1:0]  init_time_lim;
		logic [N_PART-1:0] marks;
		logic [VAL_W-1:0]  run_min;
		logic              three_body;
		logic              active_flag;
		logic [CNT_W-1:0]  formed_cnt;
		result_t           pending_results[$];
		int                mismatches;

		function new();
			bound_radius   = '0;
			shell_margin   = '0;
			contact_factor = CF_RESET;
			min_time_step  = '0;
			init_time_lim  = TIME_LIM_RESET;
			mismatches     = 0;
			begin_pass();
		endfunction

		function void begin_pass();
			marks       = '0;
			run_min     = init_time_lim;
			three_body  = 1'b0;
			active_flag = 1'b1;
			formed_cnt  = '0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] val);
			case (idx)
				CFG_BOUND_RADIUS:   bound_radius   = val;
				CFG_SHELL_MARGIN:   shell_margin   = val;
				CFG_CONTACT_FACTOR: contact_factor = val[CF_W-1:0];
				CFG_MIN_TIME_STEP:  min_time_step  = val;
				CFG_INIT_TIME_LIM:  init_time_lim  = val;
				default: ;
			endcase
		endfunction

		// distance * 2^12 < factor * (r1 + r2), no truncation
		function logic touching(logic [VAL_W-1:0] d, logic [VAL_W-1:0] r1,
				logic [VAL_W-1:0] r2);
			logic [VAL_W:0] sum;
			logic [63:0]    lhs;
			logic [63:0]    rhs;
			sum = {1'b0, r1} + {1'b0, r2};
			lhs = 64'(d) << CF_FRAC;
			rhs = 64'(contact_factor) * 64'(sum);
			return lhs < rhs;
		endfunction

		function logic shell_clear(logic [VAL_W-1:0] c, logic [VAL_W-1:0] r);
			logic [VAL_W:0] s;
			s = {1'b0, c} + {1'b0, r};
			if (s[VAL_W] || shell_margin > bound_radius)
				return 1'b0;
			return s[VAL_W-1:0] < bound_radius - shell_margin;
		endfunction

		function logic [VAL_W-1:0] later(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
			return (a > b) ? a : b;
		endfunction

		function void note_request(item_t rq);
			result_t          r;
			logic [VAL_W-1:0] t;
			logic             unmarked;
			logic             in1;
			logic             in2;
			r = '0;
			if (rq.start_req)
				begin_pass();
			if (active_flag) begin
				if (!touching(rq.distance, rq.first_radius, rq.second_radius)) begin
					active_flag = 1'b0;
				end else if (rq.either_dissociates) begin
					// no three-body check on this path
					t = later(rq.pair_time, rq.second_boundary_time);
					if (t < run_min)
						run_min = t;
				end else begin
					unmarked = !marks[rq.first_particle] && !marks[rq.second_particle];
					in1 = shell_clear(rq.first_center_dist, rq.first_radius);
					in2 = shell_clear(rq.second_center_dist, rq.second_radius);
					if (unmarked && in1 && in2) begin
						marks[rq.first_particle]  = 1'b1;
						marks[rq.second_particle] = 1'b1;
						if (formed_cnt != CNT_MAX)
							formed_cnt++;
						r.formed = 1'b1;
						r.first  = rq.first_particle;
						r.second = rq.second_particle;
						r.pdist  = rq.distance;
					end else begin
						t = rq.pair_time;
						if (unmarked)
							t = in1 ? later(rq.pair_time, rq.second_boundary_time)
								: later(rq.pair_time, rq.first_boundary_time);
						if (t < run_min)
							run_min = t;
						if (run_min < min_time_step) begin
							three_body  = 1'b1;
							active_flag = 1'b0;
						end
					end
				end
			end
			r.count  = formed_cnt;
			r.tstep  = run_min;
			r.three  = three_body;
			r.active = active_flag;
			pending_results = {pending_results, r};
		endfunction

		function void compare(string tag, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
			if (want !== got) begin
				if (mismatches < PRINT_LIMIT)
					$display("%0t: %s expected %h got %h", $time, tag, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				if (mismatches < PRINT_LIMIT)
					$display("%0t: result with nothing expected, got %h", $time, got);
				mismatches++;
				return;
			end
			want = pending_results.pop_front();
			compare("formed_pair", VAL_W'(want.formed), VAL_W'(got.formed));
			compare("pair_first", VAL_W'(want.first), VAL_W'(got.first));
			compare("pair_second", VAL_W'(want.second), VAL_W'(got.second));
			compare("pair_distance", want.pdist, got.pdist);
			compare("pair_count", VAL_W'(want.count), VAL_W'(got.count));
			compare("time_step", want.tstep, got.tstep);
			compare("three_body", VAL_W'(want.three), VAL_W'(got.three));
			compare("pass_active", VAL_W'(want.active), VAL_W'(got.active));
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [VAL_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic                 start_req;
	logic [IDX_W-1:0]     first_particle;
	logic [IDX_W-1:0]     second_particle;
	logic [VAL_W-1:0]     distance;
	logic [VAL_W-1:0]     pair_time;
	logic [VAL_W-1:0]     first_radius;
	logic [VAL_W-1:0]     second_radius;
	logic [VAL_W-1:0]     first_center_dist;
	logic [VAL_W-1:0]     second_center_dist;
	logic                 either_dissociates;
	logic [VAL_W-1:0]     first_boundary_time;
	logic [VAL_W-1:0]     second_boundary_time;
	logic                 out_valid;
	logic                 out_stall;
	logic                 formed_pair;
	logic [IDX_W-1:0]     pair_first;
	logic [IDX_W-1:0]     pair_second;
	logic [VAL_W-1:0]     pair_distance;
	logic [CNT_W-1:0]     pair_count;
	logic [VAL_W-1:0]     time_step;
	logic                 three_body;
	logic                 pass_active;

	pair_ledger sb;

	// idling knobs of the sender and the receiver, and item and idle counters
	logic tx_quiet;
	logic rx_quiet;
	logic hold_go;
	int   hold_left;
	int   live_items;
	int   idle_cycles;

	particle_pair_selector uut (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 80)
			return $urandom_range(1, 3);
		if (p < 95)
			return $urandom_range(4, 10);
		return $urandom_range(15, 40);
	endfunction

	// receiver: random stall bursts, quiet stretches, one long hold-off
	initial begin
		int burst;
		burst     = 0;
		out_stall = 1'b0;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (hold_go) begin
				hold_go   = 1'b0;
				hold_left = LONG_HOLD - 1;
				out_stall <= 1'b1;
			end else if (rx_quiet) begin
				out_stall <= 1'b0;
			end else if (burst > 0) begin
				burst--;
				out_stall <= 1'b1;
			end else if ($urandom_range(0, 99) < 25) begin
				burst = pick_len() - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// result monitor; samples pre-edge values
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result({formed_pair, pair_first, pair_second, pair_distance,
				pair_count, time_step, three_body, pass_active});
	end

	// watchdog: cycles with no transfer on either channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Offer one request, after an optional gap, and hold it until taken.
	// Valid stays high across back-to-back requests.
	task automatic send_request(item_t rq, int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid             <= 1'b1;
		start_req            <= rq.start_req;
		first_particle       <= rq.first_particle;
		second_particle      <= rq.second_particle;
		distance             <= rq.distance;
		pair_time            <= rq.pair_time;
		first_radius         <= rq.first_radius;
		second_radius        <= rq.second_radius;
		first_center_dist    <= rq.first_center_dist;
		second_center_dist   <= rq.second_center_dist;
		either_dissociates   <= rq.either_dissociates;
		first_boundary_time  <= rq.first_boundary_time;
		second_boundary_time <= rq.second_boundary_time;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		// requests landing on a stopped pass do not count toward the total
		if (sb.active_flag || rq.start_req)
			live_items++;
		sb.note_request(rq);
	endtask

	function automatic int sender_gap();
		if (tx_quiet || hold_go || hold_left > 0)
			return 0;
		return ($urandom_range(0, 99) < 55) ? 0 : pick_len();
	endfunction

	// Sender pauses until every owed result is out, plus pipeline settle time.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// write enable is lowered by the caller after a batch of writes
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task automatic configure(logic [VAL_W-1:0] sr, logic [VAL_W-1:0] is,
			logic [VAL_W-1:0] cf, logic [VAL_W-1:0] mts, logic [VAL_W-1:0] itl);
		write_reg(CFG_BOUND_RADIUS, sr);
		write_reg(CFG_SHELL_MARGIN, is);
		write_reg(CFG_CONTACT_FACTOR, cf);
		write_reg(CFG_MIN_TIME_STEP, mts);
		write_reg(CFG_INIT_TIME_LIM, itl);
	endtask

	// center distance that puts the shell inside the boundary most of the time
	function automatic logic [VAL_W-1:0] place(logic [VAL_W-1:0] span, logic [VAL_W-1:0] r);
		if ($urandom_range(0, 99) < 75 && span > r + 1)
			return $urandom_range(0, span - r - 1);
		return $urandom();
	endfunction

	// times spread over many magnitudes so the three-body threshold is hit
	function automatic logic [VAL_W-1:0] spread();
		return $urandom() >> $urandom_range(0, 26);
	endfunction

	// Mostly well-formed passes: a start, then candidates in contact that form
	// pairs or lower the minimum; the rest is raw noise.
	function automatic item_t random_request();
		item_t            rq;
		logic [VAL_W-1:0] span;
		logic [63:0]      lim;
		if ($urandom_range(0, 99) < 8) begin
			rq.start_req            = 1'($urandom_range(0, 1));
			rq.first_particle       = IDX_W'($urandom_range(0, 255));
			rq.second_particle      = IDX_W'($urandom_range(0, 255));
			rq.distance             = $urandom();
			rq.pair_time            = $urandom();
			rq.first_radius         = $urandom();
			rq.second_radius        = $urandom();
			rq.first_center_dist    = $urandom();
			rq.second_center_dist   = $urandom();
			rq.either_dissociates   = 1'($urandom_range(0, 1));
			rq.first_boundary_time  = $urandom();
			rq.second_boundary_time = $urandom();
			return rq;
		end
		span = (sb.shell_margin > sb.bound_radius) ? '0 : sb.bound_radius - sb.shell_margin;
		rq.start_req = sb.active_flag ? ($urandom_range(0, 99) < 4)
			: ($urandom_range(0, 99) < 85);
		// small pool of indices so marked particles come up often
		rq.first_particle  = IDX_W'(($urandom_range(0, 99) < 70) ? $urandom_range(0, 23)
			: $urandom_range(0, 255));
		rq.second_particle = IDX_W'(($urandom_range(0, 99) < 70) ? $urandom_range(0, 23)
			: $urandom_range(0, 255));
		rq.first_radius       = $urandom_range(0, 32'h0004_0000);
		rq.second_radius      = $urandom_range(0, 32'h0004_0000);
		rq.first_center_dist  = place(span, rq.first_radius);
		rq.second_center_dist = place(span, rq.second_radius);
		lim = (64'(sb.contact_factor) * (64'(rq.first_radius) + 64'(rq.second_radius)))
			>> CF_FRAC;
		if ($urandom_range(0, 99) < 92 && lim != 0)
			rq.distance = $urandom_range(0,
				(lim - 1 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(lim - 1));
		else
			rq.distance = (lim > 64'hFFFF_FFFF) ? $urandom()
				: $urandom_range(32'(lim), 32'hFFFF_FFFF);
		rq.pair_time            = spread();
		rq.first_boundary_time  = spread();
		rq.second_boundary_time = spread();
		rq.either_dissociates   = ($urandom_range(0, 99) < 15);
		return rq;
	endfunction

	// well inside the phase-0 sphere, in contact, slow times
	function automatic item_t plain_request(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b);
		item_t rq;
		rq.start_req            = 1'b0;
		rq.first_particle       = a;
		rq.second_particle      = b;
		rq.distance             = 32'h0000_8000;
		rq.pair_time            = 32'h0010_0000;
		rq.first_radius         = 32'h0001_0000;
		rq.second_radius        = 32'h0001_0000;
		rq.first_center_dist    = 32'h0002_0000;
		rq.second_center_dist   = 32'h0002_0000;
		rq.either_dissociates   = 1'b0;
		rq.first_boundary_time  = 32'h0020_0000;
		rq.second_boundary_time = 32'h0030_0000;
		return rq;
	endfunction

	// Directed cases for the phase-0 setup: sphere 64.0, shell 1.0, factor 1.0,
	// threshold 1/256. The first request rides on the pass opened by reset.
	task automatic directed_requests();
		item_t rq;
		send_request(plain_request(1, 2), sender_gap());       // forms
		rq = plain_request(1, 2);                               // marked, pair time alone
		send_request(rq, sender_gap());
		rq = plain_request(3, 4);                               // first shell wraps: outside
		rq.first_center_dist   = 32'hFFFF_0000;
		rq.pair_time           = 32'h0000_4000;
		rq.first_boundary_time = 32'h0008_0000;
		send_request(rq, sender_gap());
		rq = plain_request(5, 6);                               // second shell on the edge
		rq.second_center_dist   = 32'h003F_0000;
		rq.pair_time            = 32'h0000_1000;
		rq.second_boundary_time = 32'h0004_0000;
		send_request(rq, sender_gap());
		rq = plain_request(7, 8);                               // dissociating, below threshold
		rq.either_dissociates   = 1'b1;
		rq.pair_time            = '0;
		rq.second_boundary_time = 32'h0000_0010;
		send_request(rq, sender_gap());
		send_request(plain_request(9, 9), sender_gap());        // self pair
		send_request(plain_request(0, 255), sender_gap());      // index extremes
		rq = plain_request(10, 11);                             // radius sum carries out
		rq.first_radius  = '1;
		rq.second_radius = '1;
		rq.distance      = '1;
		rq.pair_time     = '1;
		send_request(rq, sender_gap());
		rq = plain_request(1, 12);                              // marked, drops under threshold
		rq.pair_time = 32'h0000_0008;
		send_request(rq, sender_gap());
		send_request(plain_request(13, 14), sender_gap());      // pass is stopped
		rq = plain_request(13, 14);                             // distance exactly at the limit
		rq.start_req = 1'b1;
		rq.distance  = 32'h0002_0000;
		send_request(rq, sender_gap());
		rq.distance  = 32'h0001_FFFF;                           // one below the limit
		send_request(rq, sender_gap());
		rq = plain_request(15, 16);
		rq.either_dissociates = 1'b1;
		rq.pair_time          = '1;
		send_request(rq, sender_gap());
		rq = plain_request(17, 18);                             // far apart, stops
		rq.distance = '1;
		send_request(rq, sender_gap());
		rq = '0;                                                // start with all fields zero
		rq.start_req = 1'b1;
		send_request(rq, sender_gap());
		rq = plain_request(20, 21);
		rq.start_req = 1'b1;
		send_request(rq, sender_gap());
		rq = plain_request(21, 22);                             // equal to threshold: no flag
		rq.pair_time = 32'h0000_0100;
		send_request(rq, sender_gap());
		rq = plain_request(30, 31);                             // first outside, boundary time wins
		rq.first_center_dist   = 32'h0050_0000;
		rq.pair_time           = 32'h0000_0050;
		rq.first_boundary_time = 32'h0000_0060;
		send_request(rq, sender_gap());
	endtask

	// every slot paired with itself: 256 pairs, count saturates
	task automatic fill_all_marks();
		item_t rq;
		for (int i = 0; i < N_PART; i++) begin
			rq           = plain_request(IDX_W'(i), IDX_W'(i));
			rq.distance  = '0;
			rq.start_req = (i == 0);
			send_request(rq, sender_gap());
		end
	endtask

	initial begin
		int    raw;
		int    target;
		item_t rq;
		sb                   = new();
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = '0;
		cfg_data             = '0;
		in_valid             = 1'b0;
		start_req            = 1'b0;
		first_particle       = '0;
		second_particle      = '0;
		distance             = '0;
		pair_time            = '0;
		first_radius         = '0;
		second_radius        = '0;
		first_center_dist    = '0;
		second_center_dist   = '0;
		either_dissociates   = 1'b0;
		first_boundary_time  = '0;
		second_boundary_time = '0;
		tx_quiet             = 1'b0;
		rx_quiet             = 1'b0;
		hold_go              = 1'b0;
		live_items           = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			drain();
			case (ph)
				0: configure(32'h0040_0000, 32'h0001_0000, 32'h0000_1000,
					32'h0000_0100, '1);
				1: configure('1, '0, 32'hA5A5_FFFF, 32'h0000_1000, 32'h0100_0000);
				// shell margin larger than the sphere: nothing fits
				2: configure(32'h0040_0000, 32'h0050_0000, 32'h0000_1000, '0, '1);
				// zero factor: no candidate is ever in contact
				3: configure('0, '0, '0, '1, '0);
				4: configure(32'h0040_0000, '0, 32'h0000_2000, 32'h0000_0800,
					32'h0000_8000);
				// threshold at max: any lowering raises the flag
				5: configure('1, '1, 32'h0000_1000, '1, '1);
				6: configure(32'h0040_0000, 32'h0001_0000, 32'h0000_1000,
					32'h0000_0400, 32'h0080_0000);
				default: configure($urandom(), $urandom(), $urandom(), $urandom(),
					$urandom());
			endcase
			// writes past the register list must be ignored
			if (ph == 0) begin
				for (int k = CFG_INIT_TIME_LIM + 1; k < (1 << CFG_IDX_W); k++)
					write_reg(CFG_IDX_W'(k), $urandom());
			end
			cfg_we <= 1'b0;
			tx_quiet = (ph == 1 || ph == 5);
			rx_quiet = (ph == 1);
			if (ph == 0)
				directed_requests();
			if (ph == 6)
				fill_all_marks();
			target     = (ph == 3) ? 60 : 130;
			live_items = 0;
			raw        = 0;
			while (live_items < target && raw < PHASE_CAP) begin
				if (ph == 6 && raw == 60)
					hold_go = 1'b1;   // block fills and backs up the request side
				if (ph == 4 && raw == 100)
					drain();
				rq = random_request();
				send_request(rq, sender_gap());
				raw++;
			end
		end

		drain();
		repeat (SETTLE) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
